@@ rtl/centered_median_filter_macros.svh @@
// Assertion macros used by the port checker of the median filter.
// No dependencies; include by bare file name.
`ifndef CENTERED_MEDIAN_FILTER_MACROS_SVH
`define CENTERED_MEDIAN_FILTER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CMF_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define CMF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cmf_pkg.sv @@
// Shared types and constants for the centered median filter.
// No dependencies; used by cmf_cell and centered_median_filter.
package cmf_pkg;

    localparam int DATA_W     = 32;
    localparam int WS_W       = 6;
    localparam int SEEN_W     = 7;
    localparam int GRP_SIZE   = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SEEN_W-1:0]       SEEN_MAX        = 7'd127;
    localparam logic [WS_W-1:0]         WS_RESET        = 6'd3;
    localparam logic [APB_ADDR_W-3:0]   REG_WINDOW_SIZE = '0;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_COUNT,
        ST_PICK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic shift;
        logic load;
        logic count;
    } t_cell_ctl;

endpackage

@@ rtl/cmf_cell.sv @@
// One window cell: y history tap, scan register and rank counter.
// Depends on cmf_pkg.
module cmf_cell #(
    parameter int RANK_W = 6
) (
    input  logic                  i_clk,
    input  cmf_pkg::t_cell_ctl    i_ctl,
    input  cmf_pkg::t_data        i_y,
    input  cmf_pkg::t_data        i_scan,
    input  cmf_pkg::t_data        i_bcast,
    input  logic                  i_done,
    input  logic [RANK_W-1:0]     i_target,
    output cmf_pkg::t_data        o_y,
    output cmf_pkg::t_data        o_scan,
    output logic                  o_done,
    output logic                  o_hit
);

    cmf_pkg::t_data      r_y;
    cmf_pkg::t_data      r_scan;
    logic                r_done;
    logic [RANK_W-1:0]   r_rank;
    logic                lower;

    // ties ordered by position: an equal value from a newer entry ranks lower
    assign lower = (i_bcast < r_y) || ((i_bcast == r_y) && !i_done);

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_y <= i_y;
        end
        if (i_ctl.load) begin
            r_scan <= r_y;
            r_done <= 1'b0;
            r_rank <= '0;
        end else if (i_ctl.count) begin
            r_scan <= i_scan;
            r_done <= i_done;
            if (lower) begin
                r_rank <= r_rank + RANK_W'(1);
            end
        end
    end

    assign o_y    = r_y;
    assign o_scan = r_scan;
    assign o_done = r_done;
    assign o_hit  = (r_rank == i_target);

endmodule

@@ rtl/centered_median_filter.sv @@
// Centered median filter. An item that yields a result runs through LOAD, a COUNT pass with
// one rank step per window entry, PICK and EMIT; that window's length k is 1 to 2h+1.
// Input is stalled until EMIT hands the result to the output register, so a new item waits
// for the last; an end mark gives up to h+1 results. Items that yield no result are taken in
// IDLE. Synchronous active-low reset, no clearing pass; window_size returns to 3. Depends on cmf_pkg and cmf_cell.
module centered_median_filter #(
    parameter int MAX_WINDOW = 63
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [cmf_pkg::DATA_W-1:0]   i_coord_x,
    input  logic signed [cmf_pkg::DATA_W-1:0]   i_value_y,
    input  logic                                i_series_end,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [cmf_pkg::DATA_W-1:0]   o_out_x,
    output logic signed [cmf_pkg::DATA_W-1:0]   o_out_y,
    output logic                                o_out_last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cmf_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [cmf_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cmf_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int HMAX   = (MAX_WINDOW - 1) / 2;
    localparam int H_W    = $clog2(HMAX + 1);
    localparam int XD     = HMAX + 1;
    localparam int K_W    = $clog2(MAX_WINDOW + 1);
    localparam int RANK_W = $clog2(MAX_WINDOW);
    localparam int CALC_W = ((K_W > cmf_pkg::SEEN_W) ? K_W : cmf_pkg::SEEN_W) + 1;
    localparam int NGRP   = (MAX_WINDOW + cmf_pkg::GRP_SIZE - 1) / cmf_pkg::GRP_SIZE;
    localparam int NSEL   = NGRP * cmf_pkg::GRP_SIZE;

    cmf_pkg::t_state                r_state, n_state;
    logic [cmf_pkg::WS_W-1:0]       r_ws;
    logic [cmf_pkg::SEEN_W-1:0]     r_seen;
    logic [cmf_pkg::SEEN_W-1:0]     r_cnt;
    logic [H_W-1:0]                 r_p;
    logic                           r_flush;
    logic [K_W-1:0]                 r_k;
    logic [RANK_W-1:0]              r_rank;
    logic [RANK_W-1:0]              r_c;
    cmf_pkg::t_data                 r_x [XD];
    cmf_pkg::t_data                 r_grp [NGRP];
    cmf_pkg::t_data                 r_out_x, r_out_y;
    logic                           r_out_last;
    logic                           r_out_valid, n_out_valid;

    cmf_pkg::t_cell_ctl             ctl;
    logic                           in_acc, out_acc, out_free, emit_go, count_end, cfg_wr;
    logic                           reg_hit;
    logic [cmf_pkg::SEEN_W-1:0]     seen_inc;
    logic [H_W-1:0]                 h;
    logic [CALC_W-1:0]              cnt_c, h_c, top_c, older_c, k_c;
    cmf_pkg::t_data                 median;

    cmf_pkg::t_data                 y_chain    [MAX_WINDOW];
    cmf_pkg::t_data                 scan_chain [MAX_WINDOW];
    logic                           done_chain [MAX_WINDOW];
    logic                           hit        [MAX_WINDOW];
    cmf_pkg::t_data                 y_in       [MAX_WINDOW];
    cmf_pkg::t_data                 scan_in    [MAX_WINDOW];
    logic                           done_in    [MAX_WINDOW];
    cmf_pkg::t_data                 sel        [NSEL];
    cmf_pkg::t_data                 grp_val    [NGRP];

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_hit = (paddr[cmf_pkg::APB_ADDR_W-1:2] == cmf_pkg::REG_WINDOW_SIZE);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
    assign prdata  = reg_hit ? cmf_pkg::APB_DATA_W'(r_ws) : '0;

    // ---------------- window arithmetic ----------------
    always_comb begin
        seen_inc = (r_seen == cmf_pkg::SEEN_MAX) ? r_seen
                                                 : r_seen + cmf_pkg::SEEN_W'(1);
        h = (CALC_W'(r_ws[cmf_pkg::WS_W-1:1]) > CALC_W'(HMAX)) ? H_W'(HMAX)
                                                              : H_W'(r_ws[cmf_pkg::WS_W-1:1]);
        cnt_c   = CALC_W'(seen_inc);
        h_c     = CALC_W'(h);
        top_c   = ((cnt_c - CALC_W'(1)) < h_c) ? (cnt_c - CALC_W'(1)) : h_c;
        // older neighbors of the emitted point, cut at the series start
        older_c = CALC_W'(r_cnt) - CALC_W'(1) - CALC_W'(r_p);
        if (older_c > h_c) begin
            older_c = h_c;
        end
        k_c = CALC_W'(r_p) + older_c + CALC_W'(1);
    end

    assign count_end = ((CALC_W'(r_c) + CALC_W'(1)) == CALC_W'(r_k));

    // ---------------- control ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            cmf_pkg::ST_IDLE: begin
                if (i_valid && (i_series_end || (cnt_c > h_c))) begin
                    n_state = cmf_pkg::ST_LOAD;
                end
            end
            cmf_pkg::ST_LOAD: begin
                n_state = cmf_pkg::ST_COUNT;
            end
            cmf_pkg::ST_COUNT: begin
                if (count_end) begin
                    n_state = cmf_pkg::ST_PICK;
                end
            end
            cmf_pkg::ST_PICK: begin
                n_state = cmf_pkg::ST_EMIT;
            end
            cmf_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = (r_flush && (r_p != '0)) ? cmf_pkg::ST_LOAD : cmf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cmf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_acc   = r_out_valid && !i_stall;
        out_free  = !r_out_valid || !i_stall;
        o_stall   = 1'b1;
        ctl       = '0;
        emit_go   = 1'b0;
        case (r_state)
            cmf_pkg::ST_IDLE: begin
                o_stall = 1'b0;
            end
            cmf_pkg::ST_LOAD: begin
                ctl.load = 1'b1;
            end
            cmf_pkg::ST_COUNT: begin
                ctl.count = 1'b1;
            end
            cmf_pkg::ST_PICK: begin
            end
            cmf_pkg::ST_EMIT: begin
                emit_go = out_free;
            end
            default: begin
            end
        endcase
        in_acc    = i_valid && !o_stall;
        ctl.shift = in_acc;
        n_out_valid = emit_go ? 1'b1 : (out_acc ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cmf_pkg::ST_IDLE;
            r_ws        <= cmf_pkg::WS_RESET;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                r_ws <= pwdata[cmf_pkg::WS_W-1:0];
            end
            if (in_acc) begin
                r_seen <= i_series_end ? '0 : seen_inc;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x[0] <= i_coord_x;
            for (int i = 1; i < XD; i++) begin
                r_x[i] <= r_x[i-1];
            end
            r_cnt   <= seen_inc;
            r_flush <= i_series_end;
            r_p     <= i_series_end ? H_W'(top_c) : h;
        end
        if (ctl.load) begin
            r_k    <= K_W'(k_c);
            r_rank <= RANK_W'(k_c >> 1);
            r_c    <= '0;
        end
        if (ctl.count) begin
            r_c <= r_c + RANK_W'(1);
        end
        if (r_state == cmf_pkg::ST_PICK) begin
            for (int g = 0; g < NGRP; g++) begin
                r_grp[g] <= grp_val[g];
            end
        end
        if (emit_go) begin
            r_out_x    <= r_x[r_p];
            r_out_y    <= median;
            r_out_last <= r_flush && (r_p == '0);
            if (r_flush && (r_p != '0)) begin
                r_p <= r_p - H_W'(1);
            end
        end
    end

    // ---------------- cell chain ----------------
    // scan values move toward cell 0, whose scan register drives the compare line;
    // the done flags move the other way and mark entries already broadcast
    for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
        if (j == 0) begin : g_head
            assign y_in[j]    = i_value_y;
            assign done_in[j] = 1'b1;
        end else begin : g_body
            assign y_in[j]    = y_chain[j-1];
            assign done_in[j] = done_chain[j-1];
        end
        if (j == MAX_WINDOW - 1) begin : g_tail
            assign scan_in[j] = '0;
        end else begin : g_link
            assign scan_in[j] = scan_chain[j+1];
        end

        cmf_cell #(
            .RANK_W (RANK_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_y      (y_in[j]),
            .i_scan   (scan_in[j]),
            .i_bcast  (scan_chain[0]),
            .i_done   (done_in[j]),
            .i_target (r_rank),
            .o_y      (y_chain[j]),
            .o_scan   (scan_chain[j]),
            .o_done   (done_chain[j]),
            .o_hit    (hit[j])
        );

        assign sel[j] = (hit[j] && (K_W'(j) < r_k)) ? y_chain[j] : '0;
    end

    for (genvar j = MAX_WINDOW; j < NSEL; j++) begin : g_pad
        assign sel[j] = '0;
    end

    // median pick: exactly one cell in the window holds the target rank
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_val[g] = '0;
            for (int i = 0; i < cmf_pkg::GRP_SIZE; i++) begin
                grp_val[g] = grp_val[g] | sel[g * cmf_pkg::GRP_SIZE + i];
            end
        end
        median = '0;
        for (int g = 0; g < NGRP; g++) begin
            median = median | r_grp[g];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_x    = r_out_x;
    assign o_out_y    = r_out_y;
    assign o_out_last = r_out_last;

endmodule

@@ rtl/cmf_port_chk.sv @@
// Port-level checker for centered_median_filter, bound to the top level below.
// Depends on centered_median_filter_macros.svh and cmf_pkg.
`include "centered_median_filter_macros.svh"

module cmf_port_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                i_series_end,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [cmf_pkg::DATA_W-1:0]   o_out_x,
    input logic signed [cmf_pkg::DATA_W-1:0]   o_out_y,
    input logic                                o_out_last,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [cmf_pkg::APB_ADDR_W-1:0]      paddr,
    input logic [cmf_pkg::APB_DATA_W-1:0]      pwdata,
    input logic [cmf_pkg::APB_DATA_W-1:0]      prdata
);

    // stalled result beat keeps its valid
    `CMF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid, "result beat dropped while stalled")
    // stalled result beat keeps its payload
    `CMF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_out_x) && $stable(o_out_y) && $stable(o_out_last), "result payload changed while stalled")
    // an end mark always leaves work to do
    `CMF_ASSERT_NEXT(a_end_busy, i_clk, i_rst_n, i_valid && !o_stall && i_series_end, o_stall, "end mark accepted without flush")
    // window_size readback follows the last write
    `CMF_ASSERT_NEXT(a_cfg_rb, i_clk, i_rst_n, psel && penable && pwrite && !paddr[2], !(psel && !pwrite && !paddr[2]) || (prdata[cmf_pkg::WS_W-1:0] == $past(pwdata[cmf_pkg::WS_W-1:0])), "window_size readback mismatch")
    // unused register bits read as zero
    `CMF_ASSERT_SAME(a_cfg_zero, i_clk, i_rst_n, psel && !pwrite, prdata[cmf_pkg::APB_DATA_W-1:cmf_pkg::WS_W] == '0, "reserved register bits nonzero")

endmodule

bind centered_median_filter cmf_port_chk u_port_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_series_end (i_series_end),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_out_x      (o_out_x),
    .o_out_y      (o_out_y),
    .o_out_last   (o_out_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata)
);

@@ bench/testbench.sv @@
// Self-checking bench for centered_median_filter: random and directed point series.
// Predicts each filtered point in SystemVerilog and checks it beat by beat.
// Depends on cmf_pkg and the filter RTL only.
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_WIN      = 63;
    localparam int X_DEPTH      = MAX_WIN / 2 + 1;
    localparam int DRAIN_CYCLES = 2 * MAX_WIN + 8;
    localparam logic [cmf_pkg::APB_ADDR_W-1:0] WINDOW_ADDR = {cmf_pkg::REG_WINDOW_SIZE, 2'b00};

    typedef struct packed {
        cmf_pkg::t_data x;
        cmf_pkg::t_data y;
        logic           last;
    } t_filtered_point;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    cmf_pkg::t_data                 i_coord_x;
    cmf_pkg::t_data                 i_value_y;
    logic                           i_series_end;
    logic                           o_valid;
    logic                           i_stall;
    cmf_pkg::t_data                 o_out_x;
    cmf_pkg::t_data                 o_out_y;
    logic                           o_out_last;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [cmf_pkg::APB_ADDR_W-1:0] paddr;
    logic [cmf_pkg::APB_DATA_W-1:0] pwdata;
    logic [cmf_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // predictor state
    cmf_pkg::t_data             y_hist [MAX_WIN];
    cmf_pkg::t_data             x_hist [X_DEPTH];
    logic [cmf_pkg::SEEN_W-1:0] seen_cnt;
    logic [cmf_pkg::WS_W-1:0]   span_cfg;
    t_filtered_point            expected_points [$];

    int error_count     = 0;
    int items_sent      = 0;
    int points_checked  = 0;
    int series_count    = 0;
    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;

    centered_median_filter #(.MAX_WINDOW(MAX_WIN)) uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(40_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void flag_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t ERROR: %s", $time, msg);
    endfunction

    // upper median of the k newest y values, signed order
    function automatic cmf_pkg::t_data upper_median(int k);
        cmf_pkg::t_data sorted [MAX_WIN];
        cmf_pkg::t_data key;
        int i, j;
        for (i = 0; i < k; i++) begin
            key = y_hist[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        return sorted[k/2];
    endfunction

    function automatic void queue_point(int p, int cnt, int h, logic last);
        t_filtered_point pt;
        int older;
        older = cnt - 1 - p;
        if (older > h)
            older = h;
        pt.x    = x_hist[p];
        pt.y    = upper_median(p + older + 1);
        pt.last = last;
        expected_points.insert(expected_points.size(), pt);
    endfunction

    function automatic void filter_point(cmf_pkg::t_data x, cmf_pkg::t_data y,
                                         logic end_mark);
        int h, cnt, top, i, p;
        h = span_cfg / 2;
        if (h > (MAX_WIN - 1) / 2)
            h = (MAX_WIN - 1) / 2;
        for (i = MAX_WIN - 1; i > 0; i--)
            y_hist[i] = y_hist[i-1];
        for (i = X_DEPTH - 1; i > 0; i--)
            x_hist[i] = x_hist[i-1];
        y_hist[0] = y;
        x_hist[0] = x;
        if (seen_cnt < cmf_pkg::SEEN_MAX)
            seen_cnt++;
        cnt = seen_cnt;
        if (!end_mark) begin
            if (cnt > h)
                queue_point(h, cnt, h, 1'b0);
        end else begin
            // flush everything not yet emitted, oldest first
            top = (cnt - 1 < h) ? cnt - 1 : h;
            for (p = top; p >= 0; p--)
                queue_point(p, cnt, h, p == 0);
            seen_cnt = '0;
            series_count++;
        end
    endfunction

    function automatic cmf_pkg::t_data rand_level();
        cmf_pkg::t_data v;
        case ($urandom_range(3))
            0: v = (cmf_pkg::t_data'($urandom_range(6)) - 32'sd3) <<< 16;   // ties
            1: begin
                case ($urandom_range(3))
                    0: v = cmf_pkg::t_data'(32'h8000_0000);
                    1: v = cmf_pkg::t_data'(32'h7FFF_FFFF);
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = cmf_pkg::t_data'($urandom);
        endcase
        return v;
    endfunction

    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < sink_stall_pct);

    always @(posedge i_clk) begin : check_output
        t_filtered_point want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_points.size() == 0) begin
                flag_error($sformatf("unexpected point x=%h y=%h last=%b",
                                     o_out_x, o_out_y, o_out_last));
            end else begin
                want = expected_points.pop_front();
                points_checked++;
                if (o_out_x !== want.x || o_out_y !== want.y || o_out_last !== want.last)
                    flag_error($sformatf(
                        "point mismatch: exp x=%h y=%h last=%b, got x=%h y=%h last=%b",
                        want.x, want.y, want.last, o_out_x, o_out_y, o_out_last));
            end
        end
    end

    task automatic send_point(input cmf_pkg::t_data x, input cmf_pkg::t_data y,
                              input logic end_mark);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_coord_x    <= x;
        i_value_y    <= y;
        i_series_end <= end_mark;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        filter_point(x, y, end_mark);
        items_sent++;
    endtask

    // drop valid, let all results come out, then give in-flight work time to finish
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_span(input int value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= cmf_pkg::APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[cmf_pkg::WS_W-1:0] !== cmf_pkg::WS_W'(value))
            flag_error($sformatf("window_size readback: exp %0d got %0d",
                                 value, prdata[cmf_pkg::WS_W-1:0]));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        span_cfg = cmf_pkg::WS_W'(value);
    endtask

    // reset span of 3, signed extremes on both fields
    task automatic test_default_span();
        send_point(cmf_pkg::t_data'(32'h8000_0000), cmf_pkg::t_data'(32'h7FFF_FFFF), 1'b0);
        send_point(cmf_pkg::t_data'(32'h7FFF_FFFF), cmf_pkg::t_data'(32'h8000_0000), 1'b0);
        send_point('0, '0, 1'b0);
        send_point('1, '1, 1'b0);
        send_point(cmf_pkg::t_data'(32'h1234_5678), cmf_pkg::t_data'(32'h0005_0000), 1'b1);
    endtask

    task automatic test_pass_through();
        wait_idle();
        write_span(0);
        send_point(cmf_pkg::t_data'(32'h0001_0000), cmf_pkg::t_data'(32'h8000_0000), 1'b0);
        send_point(cmf_pkg::t_data'(32'h0002_0000), cmf_pkg::t_data'(32'h7FFF_FFFF), 1'b0);
        send_point(cmf_pkg::t_data'(32'h0003_0000), cmf_pkg::t_data'(32'hFFFF_0000), 1'b1);
        wait_idle();
        write_span(1);
        send_point(cmf_pkg::t_data'(32'hDEAD_BEEF), cmf_pkg::t_data'(32'h0000_0001), 1'b0);
        send_point(cmf_pkg::t_data'(32'h0BAD_F00D), cmf_pkg::t_data'(32'hFFFF_FFFF), 1'b1);
    endtask

    // series shorter than the window, an even span, widest span
    task automatic test_short_series();
        wait_idle();
        write_span(4);
        send_point(cmf_pkg::t_data'(32'h0000_0100), cmf_pkg::t_data'(32'h0042_0000), 1'b1);
        send_point(cmf_pkg::t_data'(32'h0000_0200), cmf_pkg::t_data'(32'hFFFE_0000), 1'b0);
        send_point(cmf_pkg::t_data'(32'h0000_0300), cmf_pkg::t_data'(32'h0002_0000), 1'b1);
        wait_idle();
        write_span(63);
        send_point(cmf_pkg::t_data'(32'h7000_0000), cmf_pkg::t_data'(32'h0003_0000), 1'b0);
        send_point(cmf_pkg::t_data'(32'h7000_0001), cmf_pkg::t_data'(32'h0003_0000), 1'b0);
        send_point(cmf_pkg::t_data'(32'h7000_0002), cmf_pkg::t_data'(32'h8000_0000), 1'b1);
    endtask

    // span rewritten while a series is open: points can be skipped or repeated
    task automatic test_span_change();
        wait_idle();
        write_span(5);
        send_point(cmf_pkg::t_data'(32'h0000_1000), cmf_pkg::t_data'(32'h0009_0000), 1'b0);
        send_point(cmf_pkg::t_data'(32'h0000_2000), cmf_pkg::t_data'(32'h0001_0000), 1'b0);
        send_point(cmf_pkg::t_data'(32'h0000_3000), cmf_pkg::t_data'(32'h0007_0000), 1'b0);
        send_point(cmf_pkg::t_data'(32'h0000_4000), cmf_pkg::t_data'(32'h0003_0000), 1'b0);
        wait_idle();
        write_span(9);
        send_point(cmf_pkg::t_data'(32'h0000_5000), cmf_pkg::t_data'(32'hFFF0_0000), 1'b0);
        send_point(cmf_pkg::t_data'(32'h0000_6000), cmf_pkg::t_data'(32'h0010_0000), 1'b0);
        wait_idle();
        write_span(2);
        send_point(cmf_pkg::t_data'(32'h0000_7000), cmf_pkg::t_data'(32'h0000_8000), 1'b1);
    endtask

    // series longer than the saturating point counter
    task automatic test_long_series();
        int i;
        wait_idle();
        write_span(4);
        for (i = 0; i < 130; i++)
            send_point(cmf_pkg::t_data'($urandom), rand_level(), i == 129);
    endtask

    task automatic test_random_series(input int phase, input int target);
        int first_item, span, len, cut, i, s;
        first_item = items_sent;
        s = 0;
        while (items_sent - first_item < target) begin
            if (s == 0 && phase == 0) begin
                span = 63;
                len  = 2 * (span / 2) + 3;
            end else begin
                case ($urandom_range(9))
                    0: span = $urandom_range(63);
                    1: span = $urandom_range(1);
                    default: span = $urandom_range(2, 9);
                endcase
                len = $urandom_range(1, 2 * (span / 2) + 5);
            end
            cut = ($urandom_range(5) == 0 && len > 1) ? $urandom_range(1, len - 1) : 0;
            wait_idle();
            write_span(span);
            for (i = 0; i < len; i++) begin
                if (cut != 0 && i == cut) begin
                    wait_idle();
                    write_span($urandom_range(12));
                end
                send_point(cmf_pkg::t_data'($urandom), rand_level(), i == len - 1);
            end
            s++;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_coord_x    = '0;
        i_value_y    = '0;
        i_series_end = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        for (int i = 0; i < MAX_WIN; i++)
            y_hist[i] = '0;
        for (int i = 0; i < X_DEPTH; i++)
            x_hist[i] = '0;
        seen_cnt = '0;
        span_cfg = cmf_pkg::WS_RESET;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct   = 6;
        sink_stall_pct = 82;
        test_default_span();
        test_pass_through();
        test_short_series();
        test_span_change();
        test_long_series();
        test_random_series(0, 80);

        src_idle_pct   = 82;
        sink_stall_pct = 6;
        test_random_series(1, 70);

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_random_series(2, 70);

        wait_idle();
        if (expected_points.size() != 0)
            flag_error($sformatf("%0d expected points never came out",
                                 expected_points.size()));

        $display("Sent %0d points in %0d series, checked %0d filtered points.",
                 items_sent, series_count, points_checked);
        $display("Spans 0 to 63, mid-series span changes, counter saturation; %0d errors.",
                 error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
